/* src/fcu_pkg.sv */
// Shared constants, widths and arithmetic helpers for the free-look camera update block.
package fcu_pkg;

  localparam int POS_BITS        = 32;
  localparam int VEC_FRAC_BITS   = 14;
  localparam int TRIG_ITERATIONS = 16;

  // vector and angle widths
  localparam int VW      = VEC_FRAC_BITS + 2;  // stored unit-vector component
  localparam int NW      = VEC_FRAC_BITS + 3;  // raw component before normalizing
  localparam int ANG_W   = 26;                 // yaw state, signed
  localparam int PITCH_W = 24;
  localparam int YAW_O_W = 25;
  localparam int SUM_W   = 29;                 // angle plus mouse step
  localparam int ZW      = 27;                 // CORDIC angle accumulator
  localparam int XW      = 34;                 // CORDIC x/y, Q2.30 plus growth
  localparam int PW      = 2 * NW;             // fixed-point product
  localparam int VEL_W   = 34;                 // speed * elapsed
  localparam int MPW     = VW + VEL_W;         // move product

  // normalize unit
  localparam int SQ_W     = 2 * NW;
  localparam int ACC_W    = 2 * NW + 2;
  localparam int SQ_STEPS = NW + 1;
  localparam int LEN_W    = NW + 1;
  localparam int DIV_W    = LEN_W + VEC_FRAC_BITS + 1;
  localparam int QB       = VEC_FRAC_BITS + 1;
  localparam int CNT_W    = 6;

  localparam logic signed [ZW-1:0] DEG_89  = ZW'(89 * 65536);
  localparam logic signed [ZW-1:0] DEG_90  = ZW'(90 * 65536);
  localparam logic signed [ZW-1:0] DEG_180 = ZW'(180 * 65536);
  localparam logic signed [ZW-1:0] DEG_360 = ZW'(360 * 65536);
  localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032875);
  localparam logic signed [VW-1:0] VEC_ONE = VW'(1 << VEC_FRAC_BITS);

  localparam int TAB_LEN = 30;
  localparam int TAB_W   = $clog2(TAB_LEN);

  // configuration register indexes
  localparam logic [2:0] REG_SPEED = 3'd0;
  localparam logic [2:0] REG_SENS  = 3'd1;
  localparam logic [2:0] REG_POS_X = 3'd2;
  localparam logic [2:0] REG_POS_Y = 3'd3;
  localparam logic [2:0] REG_POS_Z = 3'd4;

  // atan(2^-i) in Q16 degrees
  function automatic logic signed [ZW-1:0] atan_deg(input logic [TAB_W-1:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:  r = ZW'(2949120);
      5'd1:  r = ZW'(1740967);
      5'd2:  r = ZW'(919879);
      5'd3:  r = ZW'(466945);
      5'd4:  r = ZW'(234378);
      5'd5:  r = ZW'(117305);
      5'd6:  r = ZW'(58666);
      5'd7:  r = ZW'(29335);
      5'd8:  r = ZW'(14668);
      5'd9:  r = ZW'(7334);
      5'd10: r = ZW'(3667);
      5'd11: r = ZW'(1833);
      5'd12: r = ZW'(917);
      5'd13: r = ZW'(458);
      5'd14: r = ZW'(229);
      5'd15: r = ZW'(115);
      5'd16: r = ZW'(57);
      5'd17: r = ZW'(29);
      5'd18: r = ZW'(14);
      5'd19: r = ZW'(7);
      5'd20: r = ZW'(4);
      5'd21: r = ZW'(2);
      5'd22: r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // shift right by s, rounding the magnitude half away from zero
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v, input int s);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (POS_BITS - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return POS_BITS'(hi);
    if (v < lo) return POS_BITS'(lo);
    return POS_BITS'(v);
  endfunction

endpackage

/* src/fcu_cordic.sv */
// Iterative CORDIC sine/cosine unit, one rotation per cycle.
module fcu_cordic import fcu_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [ANG_W-1:0] angle_i,
  output logic                    done_o,
  output logic signed [NW-1:0]    cos_o,
  output logic signed [NW-1:0]    sin_o
);

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_F1   = 3'd1;
  localparam logic [2:0] C_F2   = 3'd2;
  localparam logic [2:0] C_IT   = 3'd3;
  localparam logic [2:0] C_RND  = 3'd4;

  logic [2:0]              st_q, st_d;
  logic [TAB_W-1:0]        it_q;
  logic signed [ZW-1:0]    z_q;
  logic signed [XW-1:0]    x_q, y_q;
  logic                    neg_q;
  logic signed [XW-1:0]    xs, ys;
  logic signed [63:0]      xr, yr;

  assign xs = x_q >>> it_q;
  assign ys = y_q >>> it_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      C_IDLE: if (start_i) st_d = C_F1;
      C_F1:   st_d = C_F2;
      C_F2:   st_d = C_IT;
      C_IT:   if (it_q == TAB_W'(TRIG_ITERATIONS - 1)) st_d = C_RND;
      C_RND:  st_d = C_IDLE;
      default: st_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= C_IDLE;
      it_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == C_IT) it_q <= it_q + 1'b1;
      else              it_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      C_IDLE: begin
        z_q   <= ZW'(angle_i);
        neg_q <= 1'b0;
      end
      C_F1: begin
        if (z_q > DEG_180)       z_q <= z_q - DEG_360;
        else if (z_q <= -DEG_180) z_q <= z_q + DEG_360;
      end
      C_F2: begin
        // fold into the right half plane, flipping both results
        if (z_q > DEG_90) begin
          z_q   <= z_q - DEG_180;
          neg_q <= 1'b1;
        end else if (z_q < -DEG_90) begin
          z_q   <= z_q + DEG_180;
          neg_q <= 1'b1;
        end
        x_q <= CORDIC_GAIN;
        y_q <= '0;
      end
      C_IT: begin
        if (!z_q[ZW-1]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atan_deg(it_q);
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atan_deg(it_q);
        end
      end
      default: ;
    endcase
  end

  assign xr     = rnd_shr(64'(x_q), 30 - VEC_FRAC_BITS);
  assign yr     = rnd_shr(64'(y_q), 30 - VEC_FRAC_BITS);
  assign cos_o  = neg_q ? NW'(-xr) : NW'(xr);
  assign sin_o  = neg_q ? NW'(-yr) : NW'(yr);
  assign done_o = (st_q == C_RND);

endmodule

/* src/fcu_norm.sv */
// Vector normalize unit: sum of squares, bit-serial square root, restoring divide.
module fcu_norm import fcu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [NW-1:0] vx_i,
  input  logic signed [NW-1:0] vy_i,
  input  logic signed [NW-1:0] vz_i,
  output logic                 done_o,
  output logic signed [VW-1:0] ux_o,
  output logic signed [VW-1:0] uy_o,
  output logic signed [VW-1:0] uz_o
);

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SQ    = 3'd1;
  localparam logic [2:0] N_SQRT  = 3'd2;
  localparam logic [2:0] N_DLOAD = 3'd3;
  localparam logic [2:0] N_DIV   = 3'd4;
  localparam logic [2:0] N_DONE  = 3'd5;

  logic [2:0]              st_q, st_d;
  logic [CNT_W-1:0]        cnt_q;
  logic [1:0]              k_q;
  logic [NW-1:0]           mag_q [3];
  logic [2:0]              sgn_q;
  logic [SQ_W-1:0]         prod_q;
  logic [ACC_W-1:0]        acc_q, n_q, r_q, b_q;
  logic [LEN_W-1:0]        len_q;
  logic [DIV_W-1:0]        dvd_q, dsr_q;
  logic [QB-1:0]           quo_q;
  logic signed [VW-1:0]    res_q [3];

  logic [NW-1:0]           sq_mag;
  logic [ACC_W:0]          sqs;
  logic                    qbit;
  logic [QB-1:0]           qn, qc;

  assign sq_mag = (cnt_q == CNT_W'(0)) ? mag_q[0] :
                  (cnt_q == CNT_W'(1)) ? mag_q[1] : mag_q[2];
  assign sqs    = (ACC_W + 1)'(r_q) + (ACC_W + 1)'(b_q);
  assign qbit   = (dvd_q >= dsr_q);
  assign qn     = {quo_q[QB-2:0], qbit};
  assign qc     = (qn > QB'(1 << VEC_FRAC_BITS)) ? QB'(1 << VEC_FRAC_BITS) : qn;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      N_IDLE:  if (start_i) st_d = N_SQ;
      N_SQ:    if (cnt_q == CNT_W'(3)) st_d = N_SQRT;
      N_SQRT:  if (cnt_q == CNT_W'(SQ_STEPS - 1)) st_d = N_DLOAD;
      N_DLOAD: st_d = N_DIV;
      N_DIV: begin
        if (cnt_q == CNT_W'(QB - 1)) st_d = (k_q == 2'd2) ? N_DONE : N_DLOAD;
      end
      N_DONE:  st_d = N_IDLE;
      default: st_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= N_IDLE;
      cnt_q <= '0;
      k_q   <= '0;
    end else begin
      st_q <= st_d;
      if (st_d != st_q) cnt_q <= '0;
      else              cnt_q <= cnt_q + 1'b1;
      if (st_q == N_IDLE) k_q <= '0;
      else if (st_q == N_DIV && cnt_q == CNT_W'(QB - 1)) k_q <= k_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      N_IDLE: begin
        sgn_q    <= {vz_i[NW-1], vy_i[NW-1], vx_i[NW-1]};
        mag_q[0] <= vx_i[NW-1] ? NW'(-vx_i) : NW'(vx_i);
        mag_q[1] <= vy_i[NW-1] ? NW'(-vy_i) : NW'(vy_i);
        mag_q[2] <= vz_i[NW-1] ? NW'(-vz_i) : NW'(vz_i);
      end
      N_SQ: begin
        prod_q <= SQ_W'(sq_mag) * SQ_W'(sq_mag);
        acc_q  <= (cnt_q == CNT_W'(0)) ? '0 : acc_q + ACC_W'(prod_q);
        n_q    <= acc_q + ACC_W'(prod_q);
        r_q    <= '0;
        b_q    <= ACC_W'(1) << (ACC_W - 2);
      end
      N_SQRT: begin
        if ({1'b0, n_q} >= sqs) begin
          n_q <= ACC_W'((ACC_W + 1)'(n_q) - sqs);
          r_q <= (r_q >> 1) + b_q;
        end else begin
          r_q <= r_q >> 1;
        end
        b_q <= b_q >> 2;
      end
      N_DLOAD: begin
        if (cnt_q == CNT_W'(0) && k_q == 2'd0) len_q <= LEN_W'(r_q);
        dvd_q <= DIV_W'({mag_q[k_q], {VEC_FRAC_BITS{1'b0}}})
               + DIV_W'(((k_q == 2'd0) ? LEN_W'(r_q) : len_q) >> 1);
        dsr_q <= DIV_W'({((k_q == 2'd0) ? LEN_W'(r_q) : len_q), {VEC_FRAC_BITS{1'b0}}});
        quo_q <= '0;
      end
      N_DIV: begin
        if (qbit) dvd_q <= dvd_q - dsr_q;
        dsr_q <= dsr_q >> 1;
        quo_q <= qn;
        if (cnt_q == CNT_W'(QB - 1)) begin
          // zero-length vector normalizes to zero
          if (len_q == '0)    res_q[k_q] <= '0;
          else if (sgn_q[k_q]) res_q[k_q] <= -$signed(VW'(qc));
          else                 res_q[k_q] <= $signed(VW'(qc));
        end
      end
      default: ;
    endcase
  end

  assign done_o = (st_q == N_DONE);
  assign ux_o   = res_q[0];
  assign uy_o   = res_q[1];
  assign uz_o   = res_q[2];

endmodule

/* src/free_look_camera_update.sv */
// Top level: free-look camera update with sequencer, move/angle datapath and shared units.
//
// One input word per frame tick on the s_axis channel: held pan keys, mouse
// deltas and elapsed milliseconds. Each accepted word yields exactly one result
// word on m_axis: position, yaw, pitch, front and up vectors.
// The cfg channel writes move speed, mouse sensitivity and start position
// (indexes 0..4, others ignored); it is always ready and meant for idle time.
// The three normalize passes dominate a tick: a sum of squares, an 18-step square
// root and three restoring divides (load plus 15 steps) on one shared unit;
// the two CORDIC passes are shorter, and the position moves on one multiplier.
// s_axis_tready_o is high only while the sequencer is idle; the next word can
// be accepted while the previous result still waits in the output register.
// If the receiver stalls, a finished tick holds in its last step until the
// output register frees up, so no result is lost or overwritten.
// Reset puts the camera at the origin, yaw -90 deg, pitch 0, front (0,0,-1),
// right (1,0,0), up (0,1,0), speed and sensitivity at their defaults.
module free_look_camera_update import fcu_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // pan_held[5:0], mouse_dx[17:6], mouse_dy[29:18], elapsed_ms[39:30]
  input  logic [39:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], yaw_deg[120:96], pitch_deg[144:121],
  // front_x/y/z[192:145], up_x/y/z[240:193], zero pad[247:241]
  output logic [247:0] m_axis_tdata_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_addr_i,
  input  logic [31:0]  cfg_data_i
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_VEL    = 4'd1;
  localparam logic [3:0] ST_MOVE   = 4'd2;
  localparam logic [3:0] ST_YAW    = 4'd3;
  localparam logic [3:0] ST_PITCH  = 4'd4;
  localparam logic [3:0] ST_TRIG_Y = 4'd5;
  localparam logic [3:0] ST_TRIG_P = 4'd6;
  localparam logic [3:0] ST_FMUL   = 4'd7;
  localparam logic [3:0] ST_NORM_F = 4'd8;
  localparam logic [3:0] ST_NORM_R = 4'd9;
  localparam logic [3:0] ST_NORM_U = 4'd10;
  localparam logic [3:0] ST_OUT    = 4'd11;

  // product slots of the fixed-point multiply step
  localparam logic [2:0] FM_CYCP = 3'd0;
  localparam logic [2:0] FM_SYCP = 3'd1;
  localparam logic [2:0] FM_R2F1 = 3'd2;
  localparam logic [2:0] FM_R2F0 = 3'd3;
  localparam logic [2:0] FM_R0F2 = 3'd4;
  localparam logic [2:0] FM_R0F1 = 3'd5;

  logic [3:0] st_q, st_d;
  logic       phase_q;
  logic [2:0] bsel_q;
  logic [1:0] comp_q;
  logic [2:0] fidx_q;

  // configuration and camera state
  logic [23:0]                speed_q;
  logic [15:0]                sens_q;
  logic signed [POS_BITS-1:0] pos_q [3];
  logic signed [ANG_W-1:0]    yaw_q;
  logic signed [PITCH_W-1:0]  pitch_q;
  logic signed [VW-1:0]       front_q [3];
  logic signed [VW-1:0]       right_q [3];
  logic signed [VW-1:0]       up_q [3];

  // per-tick scratch
  logic [5:0]            keys_q;
  logic signed [11:0]    dx_q, dy_q;
  logic [9:0]            ms_q;
  logic [VEL_W-1:0]      vel_q;
  logic [MPW-1:0]        mprod_q;
  logic                  vneg_q;
  logic signed [SUM_W-1:0] angp_q;
  logic signed [NW-1:0]  cy_q, sy_q, cp_q, sp_q;
  logic signed [PW-1:0]  fprod_q;
  logic signed [NW-1:0]  tmp_q;
  logic signed [NW-1:0]  vin_q [3];
  logic                  m_valid_q;
  logic [247:0]          m_data_q;

  logic                  s_acc;
  logic                  cor_start, cor_done;
  logic signed [NW-1:0]  cor_cos, cor_sin;
  logic                  nrm_start, nrm_done;
  logic signed [VW-1:0]  nrm_x, nrm_y, nrm_z;

  logic signed [VW-1:0]  mv_v;
  logic [VW-1:0]         mv_mag;
  logic [MPW:0]          mv_d;
  logic signed [63:0]    mv_sum;
  logic signed [SUM_W-1:0] ysum, psum;
  logic signed [NW-1:0]  fa, fb, fr;

  assign s_axis_tready_o = (st_q == ST_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:   if (s_axis_tvalid_i) st_d = ST_VEL;
      ST_VEL:    st_d = ST_MOVE;
      ST_MOVE:   if (phase_q && bsel_q == 3'd5 && comp_q == 2'd2) st_d = ST_YAW;
      ST_YAW:    if (phase_q) st_d = ST_PITCH;
      ST_PITCH:  if (phase_q) st_d = ST_TRIG_Y;
      ST_TRIG_Y: if (cor_done) st_d = ST_TRIG_P;
      ST_TRIG_P: if (cor_done) st_d = ST_FMUL;
      ST_FMUL: begin
        if (phase_q && fidx_q == FM_SYCP)      st_d = ST_NORM_F;
        else if (phase_q && fidx_q == FM_R0F1) st_d = ST_NORM_U;
      end
      ST_NORM_F: if (nrm_done) st_d = ST_NORM_R;
      ST_NORM_R: if (nrm_done) st_d = ST_FMUL;
      ST_NORM_U: if (nrm_done) st_d = ST_OUT;
      ST_OUT:    if (!m_valid_q || m_axis_tready_i) st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  // move step: vector component picked by key pair and axis
  always_comb begin
    if (bsel_q < 3'd2)      mv_v = front_q[comp_q];
    else if (bsel_q < 3'd4) mv_v = right_q[comp_q];
    else                    mv_v = (comp_q == 2'd1) ? VEC_ONE : '0;
  end
  assign mv_mag = mv_v[VW-1] ? VW'(-mv_v) : VW'(mv_v);
  assign mv_d   = ({1'b0, mprod_q} + (MPW + 1)'(1 << (VEC_FRAC_BITS - 1))) >> VEC_FRAC_BITS;
  assign mv_sum = vneg_q ? 64'(pos_q[comp_q]) - $signed(64'(mv_d))
                         : 64'(pos_q[comp_q]) + $signed(64'(mv_d));

  assign ysum = SUM_W'(yaw_q) + angp_q;
  assign psum = SUM_W'(pitch_q) - angp_q;

  always_comb begin
    unique case (fidx_q)
      FM_CYCP: begin fa = cy_q;                fb = cp_q;                end
      FM_SYCP: begin fa = sy_q;                fb = cp_q;                end
      FM_R2F1: begin fa = NW'(right_q[2]);     fb = NW'(front_q[1]);     end
      FM_R2F0: begin fa = NW'(right_q[2]);     fb = NW'(front_q[0]);     end
      FM_R0F2: begin fa = NW'(right_q[0]);     fb = NW'(front_q[2]);     end
      FM_R0F1: begin fa = NW'(right_q[0]);     fb = NW'(front_q[1]);     end
      default: begin fa = '0;                  fb = '0;                  end
    endcase
  end
  assign fr = NW'(rnd_shr(64'(fprod_q), VEC_FRAC_BITS));

  assign cor_start = (st_q == ST_TRIG_Y || st_q == ST_TRIG_P) && !phase_q;
  assign nrm_start = (st_q == ST_NORM_F || st_q == ST_NORM_R || st_q == ST_NORM_U) && !phase_q;

  fcu_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i ((st_q == ST_TRIG_Y) ? yaw_q : ANG_W'(pitch_q)),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  fcu_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (nrm_start),
    .vx_i    (vin_q[0]),
    .vy_i    (vin_q[1]),
    .vz_i    (vin_q[2]),
    .done_o  (nrm_done),
    .ux_o    (nrm_x),
    .uy_o    (nrm_y),
    .uz_o    (nrm_z)
  );

  // sequencer and camera state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      phase_q    <= 1'b0;
      bsel_q     <= '0;
      comp_q     <= '0;
      fidx_q     <= '0;
      m_valid_q  <= 1'b0;
      speed_q    <= 24'd13107;
      sens_q     <= 16'd6554;
      pos_q[0]   <= '0;
      pos_q[1]   <= '0;
      pos_q[2]   <= '0;
      yaw_q      <= ANG_W'(-DEG_90);
      pitch_q    <= '0;
      front_q[0] <= '0;
      front_q[1] <= '0;
      front_q[2] <= -VEC_ONE;
      right_q[0] <= VEC_ONE;
      right_q[1] <= '0;
      right_q[2] <= '0;
      up_q[0]    <= '0;
      up_q[1]    <= VEC_ONE;
      up_q[2]    <= '0;
    end else begin
      st_q <= st_d;

      if (st_q == ST_OUT && (!m_valid_q || m_axis_tready_i)) m_valid_q <= 1'b1;
      else if (m_valid_q && m_axis_tready_i)                 m_valid_q <= 1'b0;

      if (cfg_valid_i) begin
        unique case (cfg_addr_i)
          REG_SPEED: speed_q  <= cfg_data_i[23:0];
          REG_SENS:  sens_q   <= cfg_data_i[15:0];
          REG_POS_X: pos_q[0] <= sat_pos(64'($signed(cfg_data_i)));
          REG_POS_Y: pos_q[1] <= sat_pos(64'($signed(cfg_data_i)));
          REG_POS_Z: pos_q[2] <= sat_pos(64'($signed(cfg_data_i)));
          default: ;
        endcase
      end

      unique case (st_q)
        ST_IDLE: begin
          phase_q <= 1'b0;
          bsel_q  <= '0;
          comp_q  <= '0;
          fidx_q  <= FM_CYCP;
        end
        ST_MOVE: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            if (keys_q[bsel_q]) pos_q[comp_q] <= sat_pos(mv_sum);
            if (comp_q == 2'd2) begin
              comp_q <= '0;
              bsel_q <= bsel_q + 1'b1;
            end else begin
              comp_q <= comp_q + 1'b1;
            end
          end
        end
        ST_YAW: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            // crude wrap: below zero snaps to a full turn, beyond it to zero
            if (ysum < 0)                    yaw_q <= ANG_W'(DEG_360);
            else if (ysum > SUM_W'(DEG_360)) yaw_q <= '0;
            else                             yaw_q <= ANG_W'(ysum);
          end
        end
        ST_PITCH: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            if (psum > SUM_W'(DEG_89))       pitch_q <= PITCH_W'(DEG_89);
            else if (psum < -SUM_W'(DEG_89)) pitch_q <= PITCH_W'(-DEG_89);
            else                             pitch_q <= PITCH_W'(psum);
          end
        end
        ST_TRIG_Y, ST_TRIG_P: phase_q <= !cor_done;
        ST_FMUL: begin
          phase_q <= !phase_q;
          if (phase_q) fidx_q <= fidx_q + 1'b1;
        end
        ST_NORM_F: begin
          phase_q <= !nrm_done;
          if (nrm_done) begin
            front_q[0] <= nrm_x;
            front_q[1] <= nrm_y;
            front_q[2] <= nrm_z;
          end
        end
        ST_NORM_R: begin
          phase_q <= !nrm_done;
          if (nrm_done) begin
            right_q[0] <= nrm_x;
            right_q[1] <= nrm_y;
            right_q[2] <= nrm_z;
          end
        end
        ST_NORM_U: begin
          phase_q <= !nrm_done;
          if (nrm_done) begin
            up_q[0] <= nrm_x;
            up_q[1] <= nrm_y;
            up_q[2] <= nrm_z;
          end
        end
        default: ;
      endcase
    end
  end

  // per-tick datapath scratch
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      keys_q <= s_axis_tdata_i[5:0];
      dx_q   <= $signed(s_axis_tdata_i[17:6]);
      dy_q   <= $signed(s_axis_tdata_i[29:18]);
      ms_q   <= s_axis_tdata_i[39:30];
    end
    unique case (st_q)
      ST_VEL:  vel_q <= VEL_W'(speed_q) * VEL_W'(ms_q);
      ST_MOVE: begin
        if (!phase_q) begin
          mprod_q <= MPW'(mv_mag) * MPW'(vel_q);
          vneg_q  <= mv_v[VW-1] ^ bsel_q[0];
        end
      end
      ST_YAW:   if (!phase_q) angp_q <= SUM_W'($signed({1'b0, sens_q}) * dx_q);
      ST_PITCH: if (!phase_q) angp_q <= SUM_W'($signed({1'b0, sens_q}) * dy_q);
      ST_TRIG_Y: begin
        if (cor_done) begin
          cy_q <= cor_cos;
          sy_q <= cor_sin;
        end
      end
      ST_TRIG_P: begin
        if (cor_done) begin
          cp_q <= cor_cos;
          sp_q <= cor_sin;
        end
      end
      ST_FMUL: begin
        if (!phase_q) begin
          fprod_q <= PW'(fa) * PW'(fb);
        end else begin
          case (fidx_q)
            FM_CYCP: vin_q[0] <= fr;
            FM_SYCP: begin
              vin_q[1] <= sp_q;
              vin_q[2] <= fr;
            end
            FM_R2F1: vin_q[0] <= -fr;
            FM_R2F0: tmp_q    <= fr;
            FM_R0F2: vin_q[1] <= tmp_q - fr;
            FM_R0F1: vin_q[2] <= fr;
            default: ;
          endcase
        end
      end
      ST_NORM_F: begin
        // right = front x world up, taken from the fresh front vector
        if (nrm_done) begin
          vin_q[0] <= -NW'(nrm_z);
          vin_q[1] <= '0;
          vin_q[2] <= NW'(nrm_x);
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_data_q <= {7'd0,
                       up_q[2], up_q[1], up_q[0],
                       front_q[2], front_q[1], front_q[0],
                       pitch_q, yaw_q[YAW_O_W-1:0],
                       32'(pos_q[2]), 32'(pos_q[1]), 32'(pos_q[0])};
        end
      end
      default: ;
    endcase
  end

endmodule

/* src/fcu_checker.sv */
// Port-level checker for the free-look camera update block, bound to the top level.
module fcu_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic [39:0]  s_axis_tdata_i,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [247:0] m_axis_tdata_o,
  input logic         cfg_valid_i,
  input logic         cfg_ready_o,
  input logic [2:0]   cfg_addr_i,
  input logic [31:0]  cfg_data_i
);

  // a result word waits until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result word dropped while stalled");

  // one tick at a time: busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken again while a tick is in progress");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[144:121]) <= 24'sd5832704) &&
                        ($signed(m_axis_tdata_o[144:121]) >= -24'sd5832704))
    else $error("pitch beyond the clamp");

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[120:96] <= 25'd23592960))
    else $error("yaw beyond a full turn");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[247:241] == 7'd0))
    else $error("pad bits of result word not zero");

endmodule

bind free_look_camera_update fcu_checker u_fcu_checker (.*);
